### src/thread_priority_queue_assert.svh
// Assertion macros used by the thread priority queue top level.
`ifndef THREAD_PRIORITY_QUEUE_ASSERT_SVH
`define THREAD_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/tpq_pkg.sv
// Package with types and constants of the thread priority queue.
package tpq_pkg;

    localparam int QUEUE_DEPTH_DEF   = 16;
    localparam int PRIORITY_BITS_DEF = 8;
    localparam int ID_W              = 4;
    localparam int PRIO_FIELD_W      = 8;
    localparam int OCC_W             = 5;
    localparam int S_TDATA_W         = 16;
    localparam int M_TDATA_W         = 24;

    typedef logic [ID_W-1:0] tpq_id_t;

    typedef enum logic [1:0] {
        ACT_INSERT  = 2'd0,
        ACT_DEQUEUE = 2'd1,
        ACT_REMOVE  = 2'd2,
        ACT_FIND    = 2'd3
    } tpq_action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } tpq_status_t;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic    do_insert;
        logic    do_dequeue;
        logic    do_remove;
    } tpq_ctl_t;

endpackage

### src/thread_priority_queue.sv
// Top level of the thread priority queue: command decode, cell chain and result register.
//
// Usage: one command word enters on s_axis (action, thread id, priority) and
// exactly one result word leaves on m_axis (status, id, priority, occupancy).
// The queue is a chain of QUEUE_DEPTH cells, front entry in cell 0, kept
// sorted by ascending priority; equal priorities keep arrival order.
// Every cell compares itself with the request in parallel and shifts toward
// or away from its neighbor, so the whole chain applies each command at once.
// Latency: the result word is registered and valid the cycle after the command is accepted.
// Throughput: one command per cycle while m_axis_tready is high; the chain update
// and the single output register set that figure.
// Stall: while a result waits in the output register and m_axis_tready is
// low, s_axis_tready is low; a new word is taken in the cycle the result
// leaves.
// Reset: rst_n clears every cell's valid bit and the count, so the queue
// starts empty and no result is pending. No clearing pass is needed.
`include "thread_priority_queue_assert.svh"

module thread_priority_queue
    import tpq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [1:0] action, [5:2] thread_id, [13:6] priority_req, [15:14] zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [1:0] status, [5:2] out_thread_id, [13:6] out_priority, [18:14] occupancy,
    // [23:19] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic                     in_acc;
    tpq_action_t              action;
    tpq_id_t                  req_id;
    logic [PRIORITY_BITS-1:0] req_prio;
    tpq_ctl_t                 ctl;

    logic [QUEUE_DEPTH-1:0]   cell_valid;
    tpq_id_t                  cell_thread [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] cell_prio   [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]   cell_greater;
    tpq_id_t                  cell_sel_thread [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] cell_sel_prio   [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0]     hit_chain;

    logic                     full;
    logic                     empty;
    logic                     found;
    tpq_id_t                  found_thread;
    logic [PRIORITY_BITS-1:0] found_prio;

    tpq_status_t              res_status;
    tpq_id_t                  res_thread;
    logic [PRIORITY_BITS-1:0] res_prio;
    logic [CNT_W-1:0]         count_next;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    tpq_status_t              out_status_reg;
    tpq_id_t                  out_thread_reg;
    logic [PRIO_FIELD_W-1:0]  out_prio_reg;
    logic [OCC_W-1:0]         out_occ_reg;
    logic [CNT_W-1:0]         count_reg;

    // Unpack the command word
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign action   = tpq_action_t'(s_axis_tdata[1:0]);
    assign req_id   = s_axis_tdata[5:2];
    assign req_prio = PRIORITY_BITS'(s_axis_tdata[13:6]);

    // Queue status from the ends of the chain
    assign full  = cell_valid[QUEUE_DEPTH-1];
    assign empty = !cell_valid[0];
    assign found = hit_chain[QUEUE_DEPTH];

    // Broadcast the command to all cells
    always_comb
    begin
        ctl.do_insert  = in_acc && (action == ACT_INSERT) && !full;
        ctl.do_dequeue = in_acc && (action == ACT_DEQUEUE) && !empty;
        ctl.do_remove  = in_acc && (action == ACT_REMOVE) && found;
    end

    assign hit_chain[0] = 1'b0;

    // Build the chain of cells
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            logic                     p_valid;
            tpq_id_t                  p_thread;
            logic [PRIORITY_BITS-1:0] p_prio;
            logic                     p_greater;
            logic                     n_valid;
            tpq_id_t                  n_thread;
            logic [PRIORITY_BITS-1:0] n_prio;

            if (gi == 0)
            begin : g_front
                assign p_valid   = 1'b0;
                assign p_thread  = '0;
                assign p_prio    = '0;
                assign p_greater = 1'b0;
            end
            else
            begin : g_mid_prev
                assign p_valid   = cell_valid[gi-1];
                assign p_thread  = cell_thread[gi-1];
                assign p_prio    = cell_prio[gi-1];
                assign p_greater = cell_greater[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_back
                assign n_valid  = 1'b0;
                assign n_thread = '0;
                assign n_prio   = '0;
            end
            else
            begin : g_mid_next
                assign n_valid  = cell_valid[gi+1];
                assign n_thread = cell_thread[gi+1];
                assign n_prio   = cell_prio[gi+1];
            end

            tpq_cell #(
                .PRIORITY_BITS (PRIORITY_BITS)
            ) u_cell (
                .clk            (clk),
                .rst_n          (rst_n),
                .ctl            (ctl),
                .req_thread     (req_id),
                .new_prio       (req_prio),
                .prev_valid     (p_valid),
                .prev_thread    (p_thread),
                .prev_prio      (p_prio),
                .prev_greater   (p_greater),
                .next_valid     (n_valid),
                .next_thread    (n_thread),
                .next_prio      (n_prio),
                .hit_before_in  (hit_chain[gi]),
                .valid          (cell_valid[gi]),
                .thread         (cell_thread[gi]),
                .prio           (cell_prio[gi]),
                .greater        (cell_greater[gi]),
                .hit_before_out (hit_chain[gi+1]),
                .sel_thread     (cell_sel_thread[gi]),
                .sel_prio       (cell_sel_prio[gi])
            );
        end
    endgenerate

    // Merge the first-match entry; all other cells drive zero
    always_comb
    begin
        found_thread = '0;
        found_prio   = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            found_thread = found_thread | cell_sel_thread[i];
            found_prio   = found_prio | cell_sel_prio[i];
        end
    end

    // Form the result and the new count
    always_comb
    begin
        res_status = ST_OK;
        res_thread = '0;
        res_prio   = '0;
        count_next = count_reg;
        case (action)
            ACT_INSERT:
            begin
                if (full)
                begin
                    res_status = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ACT_DEQUEUE:
            begin
                if (empty)
                begin
                    res_status = ST_EMPTY;
                end
                else
                begin
                    res_thread = cell_thread[0];
                    res_prio   = cell_prio[0];
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ACT_REMOVE:
            begin
                if (!found)
                begin
                    res_status = ST_NOTFOUND;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ACT_FIND:
            begin
                if (!found)
                begin
                    res_status = ST_NOTFOUND;
                end
                else
                begin
                    res_thread = found_thread;
                    res_prio   = found_prio;
                end
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase
    end

    // Take a word while the output register is empty or draining
    assign s_axis_tready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_acc)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold control state under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_acc)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Capture the result word
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            out_status_reg <= res_status;
            out_thread_reg <= res_thread;
            out_prio_reg   <= PRIO_FIELD_W'(res_prio);
            out_occ_reg    <= OCC_W'(count_next);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_occ_reg, out_prio_reg, out_thread_reg, out_status_reg};

    // Checks on the chain and result path
    `TPQ_ASSERT_NOW(a_count_matches_cells, 1'b1,
        $countones(cell_valid) == count_reg,
        "count register disagrees with valid cells")
    `TPQ_ASSERT_NOW(a_cells_contiguous, 1'b1,
        (cell_valid & QUEUE_DEPTH'(cell_valid + 1'b1)) == '0,
        "valid cells do not form one run from the front")
    `TPQ_ASSERT_NEXT(a_full_insert_status, in_acc && (action == ACT_INSERT) && full,
        out_status_reg == ST_FULL && $stable(count_reg),
        "insert into full queue not rejected")
    `TPQ_ASSERT_NEXT(a_occupancy_tracks, in_acc,
        out_occ_reg == OCC_W'(count_reg),
        "reported occupancy differs from count")

endmodule

### src/tpq_cell.sv
// One slot of the sorted queue chain: holds an entry and shifts with its neighbors.
module tpq_cell
    import tpq_pkg::*;
#(
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  tpq_ctl_t                 ctl,
    input  tpq_id_t                  req_thread,
    input  logic [PRIORITY_BITS-1:0] new_prio,
    input  logic                     prev_valid,
    input  tpq_id_t                  prev_thread,
    input  logic [PRIORITY_BITS-1:0] prev_prio,
    input  logic                     prev_greater,
    input  logic                     next_valid,
    input  tpq_id_t                  next_thread,
    input  logic [PRIORITY_BITS-1:0] next_prio,
    input  logic                     hit_before_in,
    output logic                     valid,
    output tpq_id_t                  thread,
    output logic [PRIORITY_BITS-1:0] prio,
    output logic                     greater,
    output logic                     hit_before_out,
    output tpq_id_t                  sel_thread,
    output logic [PRIORITY_BITS-1:0] sel_prio
);

    logic                     valid_reg;
    logic                     valid_next;
    tpq_id_t                  thread_reg;
    tpq_id_t                  thread_next;
    logic [PRIORITY_BITS-1:0] prio_reg;
    logic [PRIORITY_BITS-1:0] prio_next;
    logic                     hit;
    logic                     first_hit;

    // Compare against the broadcast request
    assign greater        = !valid_reg || (prio_reg > new_prio);
    assign hit            = valid_reg && (thread_reg == req_thread);
    assign hit_before_out = hit_before_in || hit;
    assign first_hit      = hit && !hit_before_in;

    // Report this entry only when it is the first match
    assign sel_thread = first_hit ? thread_reg : '0;
    assign sel_prio   = first_hit ? prio_reg : '0;

    // Pick hold, shift from previous, insert new, or shift from next
    always_comb
    begin
        valid_next  = valid_reg;
        thread_next = thread_reg;
        prio_next   = prio_reg;
        if (ctl.do_insert && greater)
        begin
            if (prev_greater)
            begin
                valid_next  = prev_valid;
                thread_next = prev_thread;
                prio_next   = prev_prio;
            end
            else
            begin
                valid_next  = 1'b1;
                thread_next = req_thread;
                prio_next   = new_prio;
            end
        end
        else if (ctl.do_dequeue || (ctl.do_remove && hit_before_out))
        begin
            valid_next  = next_valid;
            thread_next = next_thread;
            prio_next   = next_prio;
        end
    end

    // Hold valid under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        thread_reg <= thread_next;
        prio_reg   <= prio_next;
    end

    assign valid  = valid_reg;
    assign thread = thread_reg;
    assign prio   = prio_reg;

endmodule

### bench/tpq_monitor.sv
// Scoreboard for the thread priority queue: watches both streams, predicts and compares.
`timescale 1ns / 100ps

module tpq_monitor
    import tpq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [S_TDATA_W-1:0] s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [M_TDATA_W-1:0] m_data,
    output int                   fail_count,
    output int                   pending,
    output int                   replies_checked,
    output int                   full_hits,
    output int                   empty_hits,
    output int                   absent_hits
);

    localparam int DEPTH = QUEUE_DEPTH_DEF;
    localparam logic [PRIO_FIELD_W-1:0] PRIO_MASK =
        PRIO_FIELD_W'((1 << PRIORITY_BITS_DEF) - 1);
    localparam int MAX_PRINTED = 50;

    typedef struct packed {
        tpq_status_t             status;
        tpq_id_t                 id;
        logic [PRIO_FIELD_W-1:0] prio;
        logic [OCC_W-1:0]        occ;
    } queue_reply_t;

    // Shadow copy of the sorted queue, front entry at index 0
    tpq_id_t                 shadow_id   [DEPTH];
    logic [PRIO_FIELD_W-1:0] shadow_prio [DEPTH];
    int                      shadow_used;

    queue_reply_t replies_due [$];
    queue_reply_t want;
    int           errs;
    int           checked;
    int           n_full;
    int           n_empty;
    int           n_absent;

    task automatic report_mismatch(string what, int got, int exp_val);
        if (errs < MAX_PRINTED)
            $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, exp_val);
        errs++;
    endtask

    // Close the gap at pos by moving later entries forward
    function automatic void close_gap(int pos);
        int i;
        for (i = pos; i + 1 < shadow_used; i++)
        begin
            shadow_id[i]   = shadow_id[i + 1];
            shadow_prio[i] = shadow_prio[i + 1];
        end
        shadow_used--;
    endfunction

    // Apply one command to the shadow queue and return the reply it causes
    function automatic queue_reply_t apply_action(tpq_action_t act, tpq_id_t tid,
                                                  logic [PRIO_FIELD_W-1:0] prio_in);
        queue_reply_t            r;
        logic [PRIO_FIELD_W-1:0] prio;
        int                      at;
        int                      hit;
        int                      i;
        r        = '0;
        r.status = ST_OK;
        prio     = prio_in & PRIO_MASK;
        hit      = -1;
        case (act)
            ACT_INSERT:
            begin
                if (shadow_used >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    // land behind every entry of equal or smaller priority
                    at = shadow_used;
                    for (i = 0; i < shadow_used; i++)
                        if (at == shadow_used && shadow_prio[i] > prio)
                            at = i;
                    for (i = shadow_used; i > at; i--)
                    begin
                        shadow_id[i]   = shadow_id[i - 1];
                        shadow_prio[i] = shadow_prio[i - 1];
                    end
                    shadow_id[at]   = tid;
                    shadow_prio[at] = prio;
                    shadow_used++;
                end
            end
            ACT_DEQUEUE:
            begin
                if (shadow_used == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.id   = shadow_id[0];
                    r.prio = shadow_prio[0];
                    close_gap(0);
                end
            end
            default:
            begin
                // remove and find act on the first entry with this id
                for (i = 0; i < shadow_used; i++)
                    if (hit < 0 && shadow_id[i] == tid)
                        hit = i;
                if (hit < 0)
                    r.status = ST_NOTFOUND;
                else if (act == ACT_REMOVE)
                    close_gap(hit);
                else
                begin
                    r.id   = shadow_id[hit];
                    r.prio = shadow_prio[hit];
                end
            end
        endcase
        r.occ = OCC_W'(shadow_used);
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            shadow_used = 0;
            replies_due.delete();
        end
        else
        begin
            // compare an outgoing reply against the oldest prediction
            if (m_valid && m_ready)
            begin
                if (replies_due.size() == 0)
                    report_mismatch("reply with nothing pending", int'(m_data), 0);
                else
                begin
                    want = replies_due.pop_front();
                    checked++;
                    if (m_data[1:0] != want.status)
                        report_mismatch("status", m_data[1:0], want.status);
                    if (m_data[5:2] != want.id)
                        report_mismatch("out_thread_id", m_data[5:2], want.id);
                    if (m_data[13:6] != want.prio)
                        report_mismatch("out_priority", m_data[13:6], want.prio);
                    if (m_data[18:14] != want.occ)
                        report_mismatch("occupancy", m_data[18:14], want.occ);
                    if (m_data[M_TDATA_W-1:19] != '0)
                        report_mismatch("padding", m_data[M_TDATA_W-1:19], 0);
                    case (want.status)
                        ST_FULL:     n_full++;
                        ST_EMPTY:    n_empty++;
                        ST_NOTFOUND: n_absent++;
                        default:     ;
                    endcase
                end
            end
            // predict the reply of an accepted command
            if (s_valid && s_ready)
                replies_due.push_back(apply_action(tpq_action_t'(s_data[1:0]), s_data[5:2],
                                                   s_data[13:6]));
        end
        // publish counters once per cycle
        fail_count      <= errs;
        pending         <= replies_due.size();
        replies_checked <= checked;
        full_hits       <= n_full;
        empty_hits      <= n_empty;
        absent_hits     <= n_absent;
    end

endmodule

### bench/testbench.sv
// Top of the thread priority queue bench: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
    import tpq_pkg::*;

    localparam int RANDOM_ITEMS = 1900;
    localparam int IDLE_PCT     = 32;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED,
        MODE_HOT
    } burst_mode_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 calm          = 1'b0;

    int fail_count;
    int pending;
    int replies_checked;
    int full_hits;
    int empty_hits;
    int absent_hits;
    int act_count [4];
    int issued;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    thread_priority_queue i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    tpq_monitor i_monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_valid         (s_axis_tvalid),
        .s_ready         (s_axis_tready),
        .s_data          (s_axis_tdata),
        .m_valid         (m_axis_tvalid),
        .m_ready         (m_axis_tready),
        .m_data          (m_axis_tdata),
        .fail_count      (fail_count),
        .pending         (pending),
        .replies_checked (replies_checked),
        .full_hits       (full_hits),
        .empty_hits      (empty_hits),
        .absent_hits     (absent_hits)
    );

    // Stall the reply side at random, except in the calm stretch
    always @(posedge clk)
        m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);

    // Offer one command word and hold it until accepted
    task automatic issue(tpq_action_t act, tpq_id_t tid, logic [PRIO_FIELD_W-1:0] prio);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, prio, tid, act};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        act_count[int'(act)]++;
        issued++;
    endtask

    // Favor the extremes and runs of equal priorities
    function automatic logic [PRIO_FIELD_W-1:0] pick_prio();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return '0;
        else if (roll < 20)
            return '1;
        else if (roll < 50)
            return PRIO_FIELD_W'($urandom_range(3));
        return PRIO_FIELD_W'($urandom_range(255));
    endfunction

    // Pick from a small id pool so remove and find often hit
    function automatic tpq_id_t pick_id(logic hot);
        if (hot || $urandom_range(99) < 40)
            return tpq_id_t'($urandom_range(3));
        return tpq_id_t'($urandom_range(15));
    endfunction

    initial
    begin
        int            burst;
        int            roll;
        int            k;
        burst_mode_t   mode;
        tpq_action_t   act;

        for (k = 0; k < 4; k++)
            act_count[k] = 0;
        issued = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-queue errors, extremes, ties, duplicate ids
        issue(ACT_DEQUEUE, 4'd0,  8'd0);
        issue(ACT_FIND,    4'd0,  8'd0);
        issue(ACT_REMOVE,  4'd15, 8'd255);
        issue(ACT_INSERT,  4'd15, 8'd255);
        issue(ACT_INSERT,  4'd0,  8'd0);
        issue(ACT_INSERT,  4'd10, 8'd0);
        issue(ACT_INSERT,  4'd5,  8'd128);
        issue(ACT_INSERT,  4'd5,  8'd64);
        issue(ACT_FIND,    4'd5,  8'd0);
        issue(ACT_REMOVE,  4'd5,  8'd0);
        issue(ACT_FIND,    4'd5,  8'd0);
        issue(ACT_REMOVE,  4'd9,  8'd0);
        issue(ACT_FIND,    4'd15, 8'd0);
        issue(ACT_DEQUEUE, 4'd0,  8'd0);
        issue(ACT_DEQUEUE, 4'd0,  8'd0);
        issue(ACT_INSERT,  4'd6,  8'd255);
        issue(ACT_DEQUEUE, 4'd0,  8'd0);
        issue(ACT_DEQUEUE, 4'd0,  8'd0);
        issue(ACT_DEQUEUE, 4'd0,  8'd0);
        issue(ACT_DEQUEUE, 4'd0,  8'd0);

        // Random bursts that push the queue to full, drain it, and churn ids
        while (issued < RANDOM_ITEMS)
        begin
            mode  = burst_mode_t'($urandom_range(3));
            burst = $urandom_range(60, 15);
            calm <= (issued >= 700 && issued < 1000);
            for (k = 0; k < burst; k++)
            begin
                roll = $urandom_range(99);
                case (mode)
                    MODE_FILL:
                        act = roll < 75 ? ACT_INSERT : roll < 85 ? ACT_FIND :
                              roll < 93 ? ACT_REMOVE : ACT_DEQUEUE;
                    MODE_DRAIN:
                        act = roll < 60 ? ACT_DEQUEUE : roll < 75 ? ACT_REMOVE :
                              roll < 85 ? ACT_FIND : ACT_INSERT;
                    MODE_HOT:
                        act = roll < 45 ? ACT_INSERT : roll < 65 ? ACT_REMOVE :
                              roll < 85 ? ACT_FIND : ACT_DEQUEUE;
                    default:
                        act = tpq_action_t'($urandom_range(3));
                endcase
                issue(act, pick_id(mode == MODE_HOT), pick_prio());
            end
        end
        s_axis_tvalid <= 1'b0;
        calm          <= 1'b0;

        // Drain outstanding replies, then watch for strays
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Sent %0d commands: %0d inserts, %0d dequeues, %0d removes, %0d finds",
                 issued, act_count[0], act_count[1], act_count[2], act_count[3]);
        $display("Checked %0d replies, %0d on a full queue, %0d on an empty one, %0d id misses",
                 replies_checked, full_hits, empty_hits, absent_hits);
        if (fail_count == 0)
            $display("[thread_priority_queue] OK");
        else
            $display("[thread_priority_queue] ERROR");
        $finish;
    end

    // Abort a hung run
    initial
    begin
        #2_000_000;
        $display("[thread_priority_queue] ERROR");
        $finish;
    end

endmodule
